[hw/rtl/wdwr_pkg.sv]
`default_nettype none

package wdwr_pkg;

    localparam int ENTRIES     = 64;
    localparam int SLOTS       = 8;
    localparam int WEIGHT_BITS = 16;
    localparam int RAND_BITS   = 32;

    localparam int IDX_BITS     = $clog2(ENTRIES);
    localparam int TOTAL_BITS   = WEIGHT_BITS + IDX_BITS;
    localparam int SLOT_BITS    = $clog2(SLOTS);
    localparam int COUNT_BITS   = $clog2(SLOTS + 1);
    localparam int DIV_CNT_BITS = $clog2(RAND_BITS);
    localparam int OP_BITS      = 2;

    localparam logic [OP_BITS-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_BITS-1:0] OP_START = 2'd1;
    localparam logic [OP_BITS-1:0] OP_DRAW  = 2'd2;

    typedef struct packed {
        logic capture;
        logic load_read;
        logic load_commit;
        logic start_round;
        logic slot_take;
        logic set_status;
        logic div_init;
        logic div_step;
        logic walk_init;
        logic walk_step;
        logic res_load;
    } wdwr_cmd_t;

    typedef struct packed {
        logic [OP_BITS-1:0] op;
        logic               round_full;
        logic               remain_zero;
        logic               div_last;
        logic               walk_hit;
        logic               walk_last;
        logic               out_busy;
    } wdwr_stat_t;

endpackage

`default_nettype wire

[hw/rtl/wdwr_item_if.sv]
`default_nettype none

interface wdwr_item_if
    import wdwr_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic [OP_BITS-1:0]     operation;
    logic [IDX_BITS-1:0]    entry_index;
    logic [WEIGHT_BITS-1:0] entry_weight;
    logic [RAND_BITS-1:0]   random_word;

    modport source (
        output valid,
        output operation,
        output entry_index,
        output entry_weight,
        output random_word,
        input  ready
    );

    modport sink (
        input  valid,
        input  operation,
        input  entry_index,
        input  entry_weight,
        input  random_word,
        output ready
    );
endinterface

`default_nettype wire

[hw/rtl/wdwr_result_if.sv]
`default_nettype none

interface wdwr_result_if
    import wdwr_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [SLOT_BITS-1:0] slot_index;
    logic [IDX_BITS-1:0]  picked_entry;
    logic                 found;
    logic                 round_full;
    logic                 status;

    modport source (
        output valid,
        output slot_index,
        output picked_entry,
        output found,
        output round_full,
        output status,
        input  ready
    );

    modport sink (
        input  valid,
        input  slot_index,
        input  picked_entry,
        input  found,
        input  round_full,
        input  status,
        output ready
    );
endinterface

`default_nettype wire

[hw/rtl/wdwr_ram.sv]
`default_nettype none

module wdwr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[hw/rtl/wdwr_ctrl.sv]
`default_nettype none

module wdwr_ctrl
    import wdwr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire wdwr_stat_t stat,
    output wdwr_cmd_t       cmd
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DISPATCH = 3'd1;
    localparam logic [2:0] S_LOAD     = 3'd2;
    localparam logic [2:0] S_DIV      = 3'd3;
    localparam logic [2:0] S_WALK     = 3'd4;
    localparam logic [2:0] S_FINISH   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = (state_reg == S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (stat.op)
                    OP_LOAD:
                    begin
                        cmd.load_read = 1'b1;
                        state_next    = S_LOAD;
                    end
                    OP_START:
                    begin
                        cmd.start_round = 1'b1;
                        state_next      = S_FINISH;
                    end
                    OP_DRAW:
                    begin
                        if (stat.round_full)
                        begin
                            cmd.set_status = 1'b1;
                            state_next     = S_FINISH;
                        end
                        else
                        begin
                            cmd.slot_take = 1'b1;
                            if (stat.remain_zero)
                            begin
                                state_next = S_FINISH;
                            end
                            else
                            begin
                                cmd.div_init = 1'b1;
                                state_next   = S_DIV;
                            end
                        end
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_LOAD:
            begin
                cmd.load_commit = 1'b1;
                state_next      = S_FINISH;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    cmd.walk_init = 1'b1;
                    state_next    = S_WALK;
                end
            end
            S_WALK:
            begin
                cmd.walk_step = 1'b1;
                if (stat.walk_hit || stat.walk_last)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!stat.out_busy)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/wdwr_dp.sv]
`default_nettype none

module wdwr_dp
    import wdwr_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire wdwr_cmd_t              cmd,
    output wdwr_stat_t                  stat,
    input  wire logic [OP_BITS-1:0]     in_operation,
    input  wire logic [IDX_BITS-1:0]    in_entry_index,
    input  wire logic [WEIGHT_BITS-1:0] in_entry_weight,
    input  wire logic [RAND_BITS-1:0]   in_random_word,
    input  wire logic                   cfg_we,
    input  wire logic [IDX_BITS-1:0]    cfg_data,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [SLOT_BITS-1:0]        out_slot_index,
    output logic [IDX_BITS-1:0]         out_picked_entry,
    output logic                        out_found,
    output logic                        out_round_full,
    output logic                        out_status
);

    // control state
    logic [IDX_BITS-1:0]   last_reg,      last_next;
    logic [TOTAL_BITS-1:0] total_reg,     total_next;
    logic [TOTAL_BITS-1:0] remain_reg,    remain_next;
    logic [COUNT_BITS-1:0] slot_cnt_reg,  slot_cnt_next;
    logic [ENTRIES-1:0]    vld_reg,       vld_next;
    logic [ENTRIES-1:0]    picked_reg,    picked_next;
    logic                  out_valid_reg, out_valid_next;

    // payload
    logic [OP_BITS-1:0]      op_reg,       op_next;
    logic [IDX_BITS-1:0]     idx_reg,      idx_next;
    logic [WEIGHT_BITS-1:0]  wt_reg,       wt_next;
    logic [RAND_BITS-1:0]    div_word_reg, div_word_next;
    logic [TOTAL_BITS-1:0]   div_rem_reg,  div_rem_next;
    logic [DIV_CNT_BITS-1:0] div_cnt_reg,  div_cnt_next;
    logic [IDX_BITS-1:0]     chk_reg,      chk_next;
    logic [SLOT_BITS-1:0]    res_slot_reg,   res_slot_next;
    logic [IDX_BITS-1:0]     res_entry_reg,  res_entry_next;
    logic                    res_found_reg,  res_found_next;
    logic                    res_full_reg,   res_full_next;
    logic                    res_status_reg, res_status_next;
    logic [SLOT_BITS-1:0]    o_slot_reg,     o_slot_next;
    logic [IDX_BITS-1:0]     o_entry_reg,    o_entry_next;
    logic                    o_found_reg,    o_found_next;
    logic                    o_full_reg,     o_full_next;
    logic                    o_status_reg,   o_status_next;

    logic                    ram_we;
    logic                    ram_re;
    logic [IDX_BITS-1:0]     ram_raddr;
    logic [WEIGHT_BITS-1:0]  ram_rdata;

    logic [TOTAL_BITS:0]     div_shift;
    logic [TOTAL_BITS:0]     div_diff;
    logic                    div_ge;
    logic [WEIGHT_BITS-1:0]  old_wt;
    logic [WEIGHT_BITS-1:0]  walk_wt;
    logic [TOTAL_BITS-1:0]   walk_wt_ext;
    logic [TOTAL_BITS-1:0]   load_total;
    logic                    walk_hit;
    logic [COUNT_BITS-1:0]   slot_cnt_inc;

    wdwr_ram #(
        .WIDTH (WEIGHT_BITS),
        .DEPTH (ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (wt_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign ram_we = cmd.load_commit;
    assign ram_re = cmd.load_read || cmd.walk_init || cmd.walk_step;

    always_comb
    begin
        if (cmd.load_read)
        begin
            ram_raddr = idx_reg;
        end
        else if (cmd.walk_init)
        begin
            ram_raddr = '0;
        end
        else
        begin
            ram_raddr = chk_reg + IDX_BITS'(1);
        end
    end

    assign div_shift   = {div_rem_reg, div_word_reg[RAND_BITS-1]};
    assign div_diff    = div_shift - {1'b0, remain_reg};
    assign div_ge      = (div_shift >= {1'b0, remain_reg});
    assign old_wt      = vld_reg[idx_reg] ? ram_rdata : '0;
    assign walk_wt     = vld_reg[chk_reg] ? ram_rdata : '0;
    assign walk_wt_ext = {{IDX_BITS{1'b0}}, walk_wt};
    assign load_total  = total_reg - {{IDX_BITS{1'b0}}, old_wt}
                       + {{IDX_BITS{1'b0}}, wt_reg};
    assign walk_hit    = !picked_reg[chk_reg] && (div_rem_reg < walk_wt_ext);
    assign slot_cnt_inc = slot_cnt_reg + COUNT_BITS'(1);

    always_comb
    begin
        stat.op          = op_reg;
        stat.round_full  = (slot_cnt_reg >= COUNT_BITS'(SLOTS));
        stat.remain_zero = (remain_reg == '0);
        stat.div_last    = (div_cnt_reg == {DIV_CNT_BITS{1'b1}});
        stat.walk_hit    = walk_hit;
        stat.walk_last   = (chk_reg == last_reg);
        stat.out_busy    = out_valid_reg && !out_ready;
    end

    always_comb
    begin
        last_next       = last_reg;
        total_next      = total_reg;
        remain_next     = remain_reg;
        slot_cnt_next   = slot_cnt_reg;
        vld_next        = vld_reg;
        picked_next     = picked_reg;
        out_valid_next  = out_valid_reg;
        op_next         = op_reg;
        idx_next        = idx_reg;
        wt_next         = wt_reg;
        div_word_next   = div_word_reg;
        div_rem_next    = div_rem_reg;
        div_cnt_next    = div_cnt_reg;
        chk_next        = chk_reg;
        res_slot_next   = res_slot_reg;
        res_entry_next  = res_entry_reg;
        res_found_next  = res_found_reg;
        res_full_next   = res_full_reg;
        res_status_next = res_status_reg;
        o_slot_next     = o_slot_reg;
        o_entry_next    = o_entry_reg;
        o_found_next    = o_found_reg;
        o_full_next     = o_full_reg;
        o_status_next   = o_status_reg;

        if (cfg_we)
        begin
            last_next = cfg_data;
        end

        if (cmd.capture)
        begin
            op_next         = in_operation;
            idx_next        = in_entry_index;
            wt_next         = in_entry_weight;
            div_word_next   = in_random_word;
            res_slot_next   = '0;
            res_entry_next  = '0;
            res_found_next  = 1'b0;
            res_full_next   = 1'b0;
            res_status_next = 1'b0;
        end

        if (cmd.load_commit)
        begin
            total_next       = load_total;
            vld_next[idx_reg] = 1'b1;
            if (remain_reg > load_total)
            begin
                remain_next = load_total;
            end
        end

        if (cmd.start_round)
        begin
            picked_next   = '0;
            remain_next   = total_reg;
            slot_cnt_next = '0;
        end

        if (cmd.set_status)
        begin
            res_status_next = 1'b1;
        end

        if (cmd.slot_take)
        begin
            res_slot_next = slot_cnt_reg[SLOT_BITS-1:0];
            slot_cnt_next = slot_cnt_inc;
            res_full_next = (slot_cnt_inc == COUNT_BITS'(SLOTS));
        end

        if (cmd.div_init)
        begin
            div_rem_next = '0;
            div_cnt_next = '0;
        end

        if (cmd.div_step)
        begin
            div_rem_next  = div_ge ? div_diff[TOTAL_BITS-1:0]
                                   : div_shift[TOTAL_BITS-1:0];
            div_word_next = {div_word_reg[RAND_BITS-2:0], 1'b0};
            div_cnt_next  = div_cnt_reg + DIV_CNT_BITS'(1);
        end

        if (cmd.walk_init)
        begin
            chk_next = '0;
        end

        if (cmd.walk_step)
        begin
            chk_next = chk_reg + IDX_BITS'(1);
            if (walk_hit)
            begin
                picked_next[chk_reg] = 1'b1;
                res_found_next       = 1'b1;
                res_entry_next       = chk_reg;
                remain_next = (remain_reg >= walk_wt_ext) ? remain_reg - walk_wt_ext : '0;
            end
            else if (!picked_reg[chk_reg])
            begin
                div_rem_next = div_rem_reg - walk_wt_ext;
            end
        end

        // drop the delivered item, then load the new one
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.res_load)
        begin
            out_valid_next = 1'b1;
            o_slot_next    = res_slot_reg;
            o_entry_next   = res_entry_reg;
            o_found_next   = res_found_reg;
            o_full_next    = res_full_reg;
            o_status_next  = res_status_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg      <= '0;
            total_reg     <= '0;
            remain_reg    <= '0;
            slot_cnt_reg  <= '0;
            vld_reg       <= '0;
            picked_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            last_reg      <= last_next;
            total_reg     <= total_next;
            remain_reg    <= remain_next;
            slot_cnt_reg  <= slot_cnt_next;
            vld_reg       <= vld_next;
            picked_reg    <= picked_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        idx_reg        <= idx_next;
        wt_reg         <= wt_next;
        div_word_reg   <= div_word_next;
        div_rem_reg    <= div_rem_next;
        div_cnt_reg    <= div_cnt_next;
        chk_reg        <= chk_next;
        res_slot_reg   <= res_slot_next;
        res_entry_reg  <= res_entry_next;
        res_found_reg  <= res_found_next;
        res_full_reg   <= res_full_next;
        res_status_reg <= res_status_next;
        o_slot_reg     <= o_slot_next;
        o_entry_reg    <= o_entry_next;
        o_found_reg    <= o_found_next;
        o_full_reg     <= o_full_next;
        o_status_reg   <= o_status_next;
    end

    assign out_valid        = out_valid_reg;
    assign out_slot_index   = o_slot_reg;
    assign out_picked_entry = o_entry_reg;
    assign out_found        = o_found_reg;
    assign out_round_full   = o_full_reg;
    assign out_status       = o_status_reg;

endmodule

`default_nettype wire

[hw/rtl/weighted_draw_without_replacement.sv]
// Channel     Dir   Interface        Carries
// item_in     in    wdwr_item_if     operation, entry_index, entry_weight, random_word
// result_out  out   wdwr_result_if   slot_index, picked_entry, found, round_full, status
// cfg         in    cfg_we/cfg_data  last_entry_index
//
// A load goes through dispatch, a weight RAM read and a commit; start and unknown
// operations and a draw on a full round or with nothing remaining end after dispatch.
// A normal draw forms the remainder bit-serially, then walks the entries, reading
// each weight from the RAM. Reset clears the weight valid bits and picked marks
// at once; no clearing pass. A stalled result holds in the output register while
// the next item is taken; that item waits to finish until the register frees.
`default_nettype none

module weighted_draw_without_replacement
    import wdwr_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    wdwr_item_if.sink                item_in,
    wdwr_result_if.source            result_out,
    input  wire logic                cfg_we,
    input  wire logic [IDX_BITS-1:0] cfg_data
);

    wdwr_cmd_t  cmd;
    wdwr_stat_t stat;

    wdwr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item_in.valid),
        .in_ready (item_in.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    wdwr_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .in_operation     (item_in.operation),
        .in_entry_index   (item_in.entry_index),
        .in_entry_weight  (item_in.entry_weight),
        .in_random_word   (item_in.random_word),
        .cfg_we           (cfg_we),
        .cfg_data         (cfg_data),
        .out_valid        (result_out.valid),
        .out_ready        (result_out.ready),
        .out_slot_index   (result_out.slot_index),
        .out_picked_entry (result_out.picked_entry),
        .out_found        (result_out.found),
        .out_round_full   (result_out.round_full),
        .out_status       (result_out.status)
    );

endmodule

`default_nettype wire

[hw/rtl/wdwr_checker.sv]
`default_nettype none

module wdwr_checker
    import wdwr_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 in_valid,
    input wire logic                 in_ready,
    input wire logic                 out_valid,
    input wire logic                 out_ready,
    input wire logic [SLOT_BITS-1:0] slot_index,
    input wire logic [IDX_BITS-1:0]  picked_entry,
    input wire logic                 found,
    input wire logic                 round_full,
    input wire logic                 status
);

    // one item at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
    else $error("item taken while previous item still in work");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |->
            slot_index == '0 && picked_entry == '0 && !found && !round_full)
    else $error("full-round flag with non-zero result fields");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> picked_entry == '0)
    else $error("entry reported without a pick");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(slot_index)
            && $stable(picked_entry) && $stable(found) && $stable(round_full)
            && $stable(status))
    else $error("stalled result changed");

endmodule

bind weighted_draw_without_replacement wdwr_checker u_wdwr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (item_in.valid),
    .in_ready     (item_in.ready),
    .out_valid    (result_out.valid),
    .out_ready    (result_out.ready),
    .slot_index   (result_out.slot_index),
    .picked_entry (result_out.picked_entry),
    .found        (result_out.found),
    .round_full   (result_out.round_full),
    .status       (result_out.status)
);

`default_nettype wire

[verif/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import wdwr_pkg::*;

    localparam logic [OP_BITS-1:0] OP_NONE = 2'd3;
    localparam int DIRECTED_ROWS = 24;
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 230;
    localparam int DRAIN_CYCLES = 110;

    typedef struct packed {
        logic [SLOT_BITS-1:0] slot_index;
        logic [IDX_BITS-1:0]  picked_entry;
        logic                 found;
        logic                 round_full;
        logic                 status;
    } draw_result_t;

    typedef struct packed {
        logic                   reconfig;
        logic [IDX_BITS-1:0]    cfg_value;
        logic [OP_BITS-1:0]     operation;
        logic [IDX_BITS-1:0]    entry_index;
        logic [WEIGHT_BITS-1:0] entry_weight;
        logic [RAND_BITS-1:0]   random_word;
        logic                   typed;
        draw_result_t           want;
    } stim_row_t;

    localparam draw_result_t RES_ZERO  = '0;
    localparam draw_result_t RES_FIRST = '{3'd0, 6'd0, 1'b1, 1'b0, 1'b0};
    localparam draw_result_t RES_FULL  = '{3'd0, 6'd0, 1'b0, 1'b0, 1'b1};

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [IDX_BITS-1:0] cfg_data;

    wdwr_item_if   item_ch ();
    wdwr_result_if result_ch ();

    weighted_draw_without_replacement dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_in    (item_ch),
        .result_out (result_ch),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data)
    );

    logic [WEIGHT_BITS-1:0] wheel_weight [ENTRIES];
    logic [ENTRIES-1:0]     wheel_picked;
    logic [TOTAL_BITS-1:0]  wheel_total;
    logic [TOTAL_BITS-1:0]  wheel_left;
    logic [COUNT_BITS-1:0]  slots_used;
    logic [IDX_BITS-1:0]    last_entry;

    draw_result_t outcomes [$];
    stim_row_t    directed [DIRECTED_ROWS];
    int           mismatches;
    bit           quiet;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic draw_result_t roulette_step(logic [OP_BITS-1:0] op,
                                                   logic [IDX_BITS-1:0] idx,
                                                   logic [WEIGHT_BITS-1:0] w,
                                                   logic [RAND_BITS-1:0] rnd);
        draw_result_t        r;
        logic [RAND_BITS-1:0] residue;
        logic                hit;
        logic [IDX_BITS-1:0] chosen;
        int                  i;
        r = '0;
        hit = 1'b0;
        chosen = '0;
        case (op)
            OP_LOAD:
            begin
                wheel_total = wheel_total - wheel_weight[idx] + w;
                wheel_weight[idx] = w;
                if (wheel_left > wheel_total)
                    wheel_left = wheel_total;
            end
            OP_START:
            begin
                wheel_picked = '0;
                wheel_left = wheel_total;
                slots_used = '0;
            end
            OP_DRAW:
            begin
                if (slots_used >= SLOTS)
                begin
                    r.status = 1'b1;
                end
                else
                begin
                    r.slot_index = slots_used[SLOT_BITS-1:0];
                    slots_used = slots_used + 1'b1;
                    if (wheel_left != 0)
                    begin
                        residue = rnd % RAND_BITS'(wheel_left);
                        for (i = 0; i <= int'(last_entry); i++)
                        begin
                            if (!hit && !wheel_picked[i])
                            begin
                                if (residue < RAND_BITS'(wheel_weight[i]))
                                begin
                                    hit = 1'b1;
                                    chosen = IDX_BITS'(i);
                                end
                                else
                                begin
                                    residue = residue - RAND_BITS'(wheel_weight[i]);
                                end
                            end
                        end
                        if (hit)
                        begin
                            wheel_picked[chosen] = 1'b1;
                            if (wheel_left >= TOTAL_BITS'(wheel_weight[chosen]))
                                wheel_left = wheel_left - TOTAL_BITS'(wheel_weight[chosen]);
                            else
                                wheel_left = '0;
                        end
                    end
                    r.picked_entry = chosen;
                    r.found = hit;
                    r.round_full = (slots_used == SLOTS);
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    function automatic int idle_span();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(30, 60);
    endfunction

    function automatic logic [WEIGHT_BITS-1:0] pick_weight();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        if (r < 5)
            return WEIGHT_BITS'($urandom_range(1, 15));
        return WEIGHT_BITS'($urandom);
    endfunction

    task automatic send_item(logic [OP_BITS-1:0] op, logic [IDX_BITS-1:0] idx,
                             logic [WEIGHT_BITS-1:0] w, logic [RAND_BITS-1:0] rnd,
                             logic typed = 1'b0, draw_result_t want = '0);
        int           gap;
        draw_result_t predicted;
        gap = idle_span();
        @(negedge clk);
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_ch.valid        <= 1'b1;
        item_ch.operation    <= op;
        item_ch.entry_index  <= idx;
        item_ch.entry_weight <= w;
        item_ch.random_word  <= rnd;
        do
            @(posedge clk);
        while (!item_ch.ready);
        predicted = roulette_step(op, idx, w, rnd);
        if (typed)
            predicted = want;
        outcomes.insert(outcomes.size(), predicted);
    endtask

    task automatic send_random_load();
        logic [IDX_BITS-1:0] idx;
        if ($urandom_range(0, 3) == 0)
            idx = IDX_BITS'($urandom_range(0, ENTRIES - 1));
        else
            idx = IDX_BITS'($urandom_range(0, int'(last_entry)));
        send_item(OP_LOAD, idx, pick_weight(), RAND_BITS'($urandom));
    endtask

    task automatic send_random_draw();
        logic [RAND_BITS-1:0] rnd;
        int                   r;
        r = $urandom_range(0, 19);
        if (r == 0)
            rnd = '0;
        else if (r == 1)
            rnd = '1;
        else
            rnd = $urandom;
        send_item(OP_DRAW, IDX_BITS'($urandom), WEIGHT_BITS'($urandom), rnd);
    endtask

    task automatic settle();
        @(negedge clk);
        item_ch.valid <= 1'b0;
        while (outcomes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_last_index(logic [IDX_BITS-1:0] value);
        settle();
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        last_entry = value;
    endtask

    always @(posedge clk)
    begin
        draw_result_t got;
        draw_result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got = '{result_ch.slot_index, result_ch.picked_entry, result_ch.found,
                    result_ch.round_full, result_ch.status};
            if (outcomes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: slot %0d entry %0d found %0b full %0b status %0b",
                             got.slot_index, got.picked_entry, got.found,
                             got.round_full, got.status);
            end
            else
            begin
                want = outcomes.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: expected slot %0d entry %0d found %0b full %0b ",
                                  "status %0b, got slot %0d entry %0d found %0b full %0b ",
                                  "status %0b"},
                                 want.slot_index, want.picked_entry, want.found,
                                 want.round_full, want.status, got.slot_index,
                                 got.picked_entry, got.found, got.round_full, got.status);
                end
            end
        end
    end

    initial
    begin
        int hold;
        hold = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                result_ch.ready <= 1'b0;
                hold--;
            end
            else
            begin
                result_ch.ready <= 1'b1;
                hold = idle_span();
            end
        end
    end

    initial
    begin
        #25ms;
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        int                  p;
        int                  n;
        int                  sent;
        bit                  first;
        logic [IDX_BITS-1:0] value;

        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_data             = '0;
        item_ch.valid        = 1'b0;
        item_ch.operation    = OP_LOAD;
        item_ch.entry_index  = '0;
        item_ch.entry_weight = '0;
        item_ch.random_word  = '0;
        mismatches           = 0;
        quiet                = 1'b0;
        for (int i = 0; i < ENTRIES; i++)
            wheel_weight[i] = '0;
        wheel_picked = '0;
        wheel_total  = '0;
        wheel_left   = '0;
        slots_used   = '0;
        last_entry   = '0;

        directed[0]  = '{1'b0, 6'd0, OP_DRAW, 6'd0, 16'h0, 32'h0, 1'b1, RES_ZERO};
        directed[1]  = '{1'b0, 6'd0, OP_NONE, 6'd63, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, RES_ZERO};
        directed[2]  = '{1'b0, 6'd0, OP_LOAD, 6'd0, 16'hFFFF, 32'h0, 1'b1, RES_ZERO};
        directed[3]  = '{1'b0, 6'd0, OP_LOAD, 6'd63, 16'hFFFF, 32'h0, 1'b1, RES_ZERO};
        directed[4]  = '{1'b0, 6'd0, OP_LOAD, 6'd5, 16'h1, 32'h0, 1'b1, RES_ZERO};
        directed[5]  = '{1'b0, 6'd0, OP_LOAD, 6'd5, 16'h0, 32'h0, 1'b1, RES_ZERO};
        directed[6]  = '{1'b0, 6'd0, OP_LOAD, 6'd5, 16'h3, 32'h0, 1'b1, RES_ZERO};
        directed[7]  = '{1'b0, 6'd0, OP_START, 6'd0, 16'h0, 32'h0, 1'b1, RES_ZERO};
        directed[8]  = '{1'b0, 6'd0, OP_DRAW, 6'd0, 16'h0, 32'h0, 1'b1, RES_FIRST};
        directed[9]  = '{1'b0, 6'd0, OP_DRAW, 6'd0, 16'h0, 32'hFFFF_FFFF, 1'b0, RES_ZERO};
        directed[10] = '{1'b0, 6'd0, OP_LOAD, 6'd63, 16'h0, 32'h0, 1'b1, RES_ZERO};
        directed[11] = '{1'b0, 6'd0, OP_DRAW, 6'd0, 16'h0, 32'h1234_5678, 1'b0, RES_ZERO};
        directed[12] = '{1'b0, 6'd0, OP_DRAW, 6'd0, 16'h0, 32'h0, 1'b0, RES_ZERO};
        directed[13] = '{1'b0, 6'd0, OP_DRAW, 6'd0, 16'h0, 32'hFFFF_FFFF, 1'b0, RES_ZERO};
        directed[14] = '{1'b0, 6'd0, OP_DRAW, 6'd0, 16'h0, 32'h8000_0001, 1'b0, RES_ZERO};
        directed[15] = '{1'b0, 6'd0, OP_DRAW, 6'd0, 16'h0, 32'h0000_0002, 1'b0, RES_ZERO};
        directed[16] = '{1'b0, 6'd0, OP_DRAW, 6'd0, 16'h0, 32'h7FFF_FFFF, 1'b0, RES_ZERO};
        directed[17] = '{1'b0, 6'd0, OP_DRAW, 6'd0, 16'h0, 32'hDEAD_BEEF, 1'b1, RES_FULL};
        directed[18] = '{1'b1, 6'd0, OP_START, 6'd0, 16'h0, 32'h0, 1'b1, RES_ZERO};
        directed[19] = '{1'b0, 6'd0, OP_LOAD, 6'd0, 16'h0, 32'h0, 1'b1, RES_ZERO};
        directed[20] = '{1'b0, 6'd0, OP_LOAD, 6'd10, 16'hFFFF, 32'h0, 1'b1, RES_ZERO};
        directed[21] = '{1'b0, 6'd0, OP_START, 6'd0, 16'h0, 32'h0, 1'b1, RES_ZERO};
        directed[22] = '{1'b0, 6'd0, OP_DRAW, 6'd0, 16'h0, 32'hFFFF_FFFF, 1'b0, RES_ZERO};
        directed[23] = '{1'b0, 6'd0, OP_LOAD, 6'd1, 16'h7, 32'h0, 1'b1, RES_ZERO};

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_last_index(IDX_BITS'(ENTRIES - 1));
        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            if (directed[i].reconfig)
                write_last_index(directed[i].cfg_value);
            send_item(directed[i].operation, directed[i].entry_index,
                      directed[i].entry_weight, directed[i].random_word,
                      directed[i].typed, directed[i].want);
        end

        for (p = 0; p < PHASES; p++)
        begin
            if (p == 0)
                value = '0;
            else if (p == 1 || p == PHASES - 1)
                value = '1;
            else
                value = IDX_BITS'($urandom_range(0, ENTRIES - 1));
            write_last_index(value);
            quiet = (p == 2 || p == 5);
            sent = 0;
            first = 1'b1;
            while (sent < PHASE_ITEMS)
            begin
                n = first ? $urandom_range(4, 16) : $urandom_range(0, 4);
                first = 1'b0;
                repeat (n)
                begin
                    send_random_load();
                    sent++;
                end
                if ($urandom_range(0, 19) == 0)
                    send_item(OP_NONE, IDX_BITS'($urandom), WEIGHT_BITS'($urandom),
                              RAND_BITS'($urandom));
                if ($urandom_range(0, 29) != 0)
                begin
                    send_item(OP_START, IDX_BITS'($urandom), WEIGHT_BITS'($urandom),
                              RAND_BITS'($urandom));
                    sent++;
                end
                if ($urandom_range(0, 19) == 0)
                    settle();
                n = $urandom_range(1, 10);
                repeat (n)
                begin
                    if ($urandom_range(0, 9) == 0)
                    begin
                        send_random_load();
                        sent++;
                    end
                    send_random_draw();
                    sent++;
                end
            end
        end

        @(negedge clk);
        item_ch.valid <= 1'b0;
        while (outcomes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
